### rtl/core/css_pkg.sv
// Package for the cluster size sampler: payload types, states and constants.
`default_nettype none
package css_pkg;

  localparam int unsigned SUM_W     = 48;
  localparam int unsigned TC_W      = 44;
  localparam int unsigned PROB_W    = 32;
  localparam int unsigned TLEN_W    = 7;
  localparam int unsigned SIZE_W    = 7;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 44;
  localparam int unsigned DCNT_W    = 6;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_CONSTANT = 1'b1;

  // Command codes.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [IDX_W-1:0]  entry_index;
    logic [PROB_W-1:0] entry_value;
    logic [PROB_W-1:0] random_value;
  } css_in_t;

  typedef struct packed {
    logic [SIZE_W-1:0] cluster_size;
    logic              uncovered;
  } css_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TREAD,
    ST_TACC,
    ST_TMUL,
    ST_TDIV,
    ST_TADD
  } css_state_t;

endpackage : css_pkg
`default_nettype wire

### rtl/core/cluster_size_sampler.sv
// Top level of the cluster size sampler: table memory, sequencer and shared datapath.
//
// Inverse-CDF cluster size sampler. A transaction with command = load writes one
// Q0.32 probability into the internal table (no result). A transaction with
// command = sample walks the table from entry 0, adding entries into a 48-bit
// saturating sum until the sum covers random_value; if the table_length entries
// run out, and tail_constant is nonzero, it continues with tail terms
// tail_constant/(i*i) until covered or i reaches TAIL_LIMIT. The result
// (cluster_size = i+1 when covered by table entry i, i+2 after tail term i;
// uncovered flag) is shown on out_data for exactly one cycle with out_valid
// high; the receiver cannot stall, so it must take it then. A load leaves
// busy low. A sample keeps busy high while it reads table entries and works
// through tail terms: table entries go through the table memory with its
// registered read port, and each tail term goes through a multiply state, the
// bit-serial restoring divider and an add state. The result shows in the first
// cycle with busy low, which is also the first cycle a new transaction can be
// taken, so a new sample cannot be taken before the last result shows. Table
// entries are undefined until loaded; sampling must only reach loaded entries.
// The user must write configuration only while busy is low; the block itself
// does not enforce it.
`default_nettype none
module cluster_size_sampler
  import css_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned TAIL_LIMIT  = 100
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire css_in_t              in_data,
  output logic                      out_valid,
  output css_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned MAXI = (TABLE_DEPTH > TAIL_LIMIT) ? TABLE_DEPTH : TAIL_LIMIT;
  localparam int unsigned IW   = $clog2(MAXI + 1);
  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned DW   = 2 * IW;
  localparam int unsigned CW   = (IW > TLEN_W) ? IW : TLEN_W;

  // Table memory
  logic [PROB_W-1:0] mem [TABLE_DEPTH];
  logic [PROB_W-1:0] rdata_r;

  // Configuration
  logic [TLEN_W-1:0] table_length_r;
  logic [TC_W-1:0]   tail_constant_r;

  // Sequencer and datapath
  css_state_t        state_r, state_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PROB_W-1:0] r_r, r_nxt;
  logic [DW-1:0]     divisor_r, divisor_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [TC_W-1:0]   qd_r, qd_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  css_out_t          out_data_r, out_data_nxt;

  logic [IW-1:0]     n_len;
  logic [SUM_W-1:0]  addend;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_add;
  logic              covered;
  logic [DW:0]       trial;
  logic [DW+1:0]     diff;
  logic [IW:0]       i_inc;
  logic              load_ok;

  // Effective table length: zero reads as one, clamp at the depth.
  always_comb begin
    logic [CW-1:0] tl_ext;
    tl_ext = CW'(table_length_r);
    if (tl_ext == '0) begin
      n_len = IW'(1);
    end else if (tl_ext > CW'(TABLE_DEPTH)) begin
      n_len = IW'(TABLE_DEPTH);
    end else begin
      n_len = IW'(tl_ext);
    end
  end

  // Shared saturating adder: table entries or tail quotients.
  assign addend   = (state_r == ST_TACC) ? SUM_W'(rdata_r) : SUM_W'(qd_r);
  assign sum_wide = {1'b0, sum_r} + {1'b0, addend};
  assign sum_add  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign covered  = ({16'b0, r_r} <= sum_add);
  assign i_inc    = {1'b0, i_r} + {{IW{1'b0}}, 1'b1};

  // Restoring divider step
  assign trial = {rem_r, qd_r[TC_W-1]};
  assign diff  = {1'b0, trial} - {2'b0, divisor_r};

  assign load_ok = ({26'b0, in_data.entry_index} < 32'(TABLE_DEPTH));

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    sum_nxt       = sum_r;
    r_nxt         = r_r;
    divisor_nxt   = divisor_r;
    rem_nxt       = rem_r;
    qd_nxt        = qd_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start && in_data.command == CMD_SAMPLE) begin
          r_nxt     = in_data.random_value;
          i_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = ST_TREAD;
        end
      end

      ST_TREAD: begin
        state_nxt = ST_TACC;
      end

      ST_TACC: begin
        sum_nxt = sum_add;
        if (covered) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.cluster_size = SIZE_W'(i_inc);
          out_data_nxt.uncovered    = 1'b0;
          state_nxt                 = ST_IDLE;
        end else if (i_inc < {1'b0, n_len}) begin
          i_nxt     = IW'(i_inc);
          state_nxt = ST_TREAD;
        end else begin
          // table exhausted: i becomes the table length
          i_nxt = n_len;
          if (tail_constant_r != '0 && n_len < IW'(TAIL_LIMIT)) begin
            state_nxt = ST_TMUL;
          end else begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.cluster_size = SIZE_W'({1'b0, n_len} + {{IW{1'b0}}, 1'b1});
            out_data_nxt.uncovered    = 1'b1;
            state_nxt                 = ST_IDLE;
          end
        end
      end

      ST_TMUL: begin
        divisor_nxt = i_r * i_r;
        rem_nxt     = '0;
        qd_nxt      = tail_constant_r;
        dcnt_nxt    = '0;
        state_nxt   = ST_TDIV;
      end

      ST_TDIV: begin
        if (!diff[DW+1]) begin
          rem_nxt = diff[DW-1:0];
          qd_nxt  = {qd_r[TC_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DW-1:0];
          qd_nxt  = {qd_r[TC_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(TC_W - 1)) begin
          state_nxt = ST_TADD;
        end
      end

      ST_TADD: begin
        sum_nxt = sum_add;
        i_nxt   = IW'(i_inc);
        if (covered) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.cluster_size = SIZE_W'(i_inc + {{IW{1'b0}}, 1'b1});
          out_data_nxt.uncovered    = 1'b0;
          state_nxt                 = ST_IDLE;
        end else if (i_inc < (IW + 1)'(TAIL_LIMIT)) begin
          state_nxt = ST_TMUL;
        end else begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.cluster_size = SIZE_W'(i_inc + {{IW{1'b0}}, 1'b1});
          out_data_nxt.uncovered    = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      table_length_r  <= TLEN_W'(1);
      tail_constant_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TABLE_LENGTH:  table_length_r  <= cfg_wdata[TLEN_W-1:0];
          CFG_TAIL_CONSTANT: tail_constant_r <= cfg_wdata[TC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    sum_r      <= sum_nxt;
    r_r        <= r_nxt;
    divisor_r  <= divisor_nxt;
    rem_r      <= rem_nxt;
    qd_r       <= qd_nxt;
    dcnt_r     <= dcnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start && in_data.command == CMD_LOAD && load_ok) begin
      mem[AW'(in_data.entry_index)] <= in_data.entry_value;
    end
    rdata_r <= mem[i_r[AW-1:0]];
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : cluster_size_sampler
`default_nettype wire
